// ===== rtl/fqir_pkg.sv =====
// Package for the FIFO queue with insert and replace.
// Holds sizes, operation and status codes, channel structs and the cell command.
// Depends on nothing.
`timescale 1ns / 1ps

package fqir_pkg;

   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = (CNT_W > 9) ? CNT_W : 9;
   localparam int WORD_W  = 32;
   localparam int SUM_W   = 40;
   localparam int ENTRY_W = 9;

   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_REPLACE = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_APPEND = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;
   localparam logic [1:0] CELL_INSERT = 2'd3;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] new_value;
      logic [8:0]               position;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] out_value;
      logic [ENTRY_W-1:0]       entry_count;
      logic signed [SUM_W-1:0]  even_total;
      logic signed [SUM_W-1:0]  odd_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
   } cell_cmd_type;

   function automatic logic signed [SUM_W-1:0] sext_word(input logic [WORD_W-1:0] w);
      sext_word = {{(SUM_W - WORD_W){w[WORD_W-1]}}, w};
   endfunction

endpackage

// ===== rtl/fqir_cell.sv =====
// One storage cell of the queue chain: a valid bit and one word.
// Takes from its neighbors on shift or insert; uses fqir_pkg.
`timescale 1ns / 1ps

module fqir_cell
   import fqir_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_cmd_type       cmd,
   input  logic [IDX_W-1:0]   cell_index,
   input  logic               prev_valid,
   input  logic [WORD_W-1:0]  prev_data,
   input  logic               next_valid,
   input  logic [WORD_W-1:0]  next_data,
   output logic               valid,
   output logic [WORD_W-1:0]  data
);

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [POS_W-1:0]  idx;

   assign idx = POS_W'(cell_index);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (cmd.mode)
         CELL_APPEND: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = cmd.value;
            end
         end
         CELL_SHIFT: begin
            valid_in = next_valid;
            data_in  = next_data;
         end
         CELL_INSERT: begin
            if (idx > cmd.position) begin
               valid_in = prev_valid;
               data_in  = prev_data;
            end else if (idx == cmd.position) begin
               valid_in = 1'b1;
               data_in  = cmd.value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ===== rtl/fifo_queue_with_insert_replace.sv =====
// Top level of the FIFO queue with insert and replace.
// Instantiates the row of fqir_cell cells and keeps count and parity sums; uses fqir_pkg.
//
//   Channel   Ports                     Direction  Transfer
//   request   start, busy, req_data     in         start high while busy low
//   result    rsp_valid, rsp_data       out        rsp_valid high for one cycle
//
// Enqueue, dequeue, insert and query act at the transfer, and the result appears in the
// cycle after it. Replace rotates the whole cell row once, checking the word in cell zero
// each cycle; busy is high during the rotation and the result appears in the cycle after
// its last step. Reset empties the queue. The receiver cannot stall results.
`timescale 1ns / 1ps

module fifo_queue_with_insert_replace
   import fqir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_ROTATE = 1'b1;

   logic                    state_ff, state_in;
   logic [IDX_W-1:0]        rot_ff, rot_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] even_ff, even_in;
   logic signed [SUM_W-1:0] odd_ff, odd_in;
   logic [WORD_W-1:0]       match_ff, nval_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   cell_cmd_type      cmd;
   logic              valid_w [DEPTH];
   logic [WORD_W-1:0] data_w [DEPTH];
   logic              wrap_valid;
   logic [WORD_W-1:0] wrap_data;
   logic              full, empty, match, accept;
   logic [POS_W-1:0]  pos_ext, cnt_ext, pos_clamp;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign accept  = start && !busy;
   assign pos_ext = POS_W'(req_data.position);
   assign cnt_ext = POS_W'(count_ff);
   assign pos_clamp = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
   assign match   = valid_w[0] && (data_w[0] == match_ff);

   always_comb begin
      state_in     = state_ff;
      rot_in       = rot_ff;
      count_in     = count_ff;
      even_in      = even_ff;
      odd_in       = odd_ff;
      rsp_valid_in = 1'b0;
      cmd.mode     = CELL_HOLD;
      cmd.value    = req_data.value;
      cmd.position = pos_clamp;
      wrap_valid   = 1'b0;
      wrap_data    = data_w[0];
      rsp_in.status    = STATUS_OK;
      rsp_in.out_value = '0;
      if (state_ff == ST_ROTATE) begin
         cmd.mode   = CELL_SHIFT;
         wrap_valid = valid_w[0];
         if (match) begin
            wrap_data = nval_ff;
            if (match_ff[0]) begin
               odd_in = odd_in - sext_word(match_ff);
            end else begin
               even_in = even_in - sext_word(match_ff);
            end
            if (nval_ff[0]) begin
               odd_in = odd_in + sext_word(nval_ff);
            end else begin
               even_in = even_in + sext_word(nval_ff);
            end
         end
         rot_in = rot_ff + IDX_W'(1);
         if (rot_ff == IDX_W'(DEPTH - 1)) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
      end else if (start) begin
         rsp_valid_in = 1'b1;
         case (req_data.op) inside
            OP_ENQUEUE, OP_INSERT: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else if (req_data.op == OP_ENQUEUE || !empty) begin
                  cmd.mode = (req_data.op == OP_ENQUEUE) ? CELL_APPEND : CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
                  if (req_data.value[0]) begin
                     odd_in = odd_ff + sext_word(req_data.value);
                  end else begin
                     even_in = even_ff + sext_word(req_data.value);
                  end
               end
            end
            OP_DEQUEUE: begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  cmd.mode         = CELL_SHIFT;
                  rsp_in.out_value = data_w[0];
                  count_in         = count_ff - CNT_W'(1);
                  if (data_w[0][0]) begin
                     odd_in = odd_ff - sext_word(data_w[0]);
                  end else begin
                     even_in = even_ff - sext_word(data_w[0]);
                  end
               end
            end
            OP_REPLACE: begin
               state_in     = ST_ROTATE;
               rot_in       = '0;
               rsp_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.entry_count = ENTRY_W'(count_in);
      rsp_in.even_total  = even_in;
      rsp_in.odd_total   = odd_in;
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic              pv, nv;
      logic [WORD_W-1:0] pd, nd;
      if (k == 0) begin : g_first
         assign pv = 1'b1;
         assign pd = req_data.value;
      end else begin : g_mid
         assign pv = valid_w[k-1];
         assign pd = data_w[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign nv = wrap_valid;
         assign nd = wrap_data;
      end else begin : g_inner
         assign nv = valid_w[k+1];
         assign nd = data_w[k+1];
      end
      fqir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cell_index (IDX_W'(k)),
         .prev_valid (pv),
         .prev_data  (pd),
         .next_valid (nv),
         .next_data  (nd),
         .valid      (valid_w[k]),
         .data       (data_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= '0;
         count_ff     <= '0;
         even_ff      <= '0;
         odd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         count_ff     <= count_in;
         even_ff      <= even_in;
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         match_ff <= req_data.value;
         nval_ff  <= req_data.new_value;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff == ST_ROTATE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_simple_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op != OP_REPLACE) |=> rsp_valid)
      else $error("A non-replace transfer produced no result.");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |=> $stable(count_ff))
      else $error("Entry count changed during a replace sweep.");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (valid_w[0] == !empty))
      else $error("Head cell occupancy disagrees with the entry count.");

endmodule
